@@ hdl/imhq_pkg.sv @@
// shared types and codes for the indexed min-heap queue
package imhq_pkg;
    localparam int unsigned ID_W       = 10;
    localparam int unsigned KEY_W      = 32;
    localparam int unsigned CNT_W      = 11;
    localparam int unsigned NODE_COUNT = 1024;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_POP = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_UPDATED  = 2'd1;
    localparam logic [1:0] ST_POPPED   = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic             req_type;
        logic [ID_W-1:0]  node_id;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  out_node;
        logic [KEY_W-1:0] out_key;
        logic [CNT_W-1:0] entry_count;
    } t_rsp;

    // one heap entry as stored in the heap ram
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_entry;
endpackage

@@ hdl/imhq_ram.sv @@
// generic single-port ram with registered read
module imhq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/indexed_min_heap_queue_top.sv @@
// indexed min-heap queue: sequencer around heap, slot and presence memories
// one item at a time: ready returns in the same cycle as its result is raised, and a
// result is held back until the previous one has been taken
// after synchronous active-low reset a clear of all presence entries blocks items
module indexed_min_heap_queue_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  imhq_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output imhq_pkg::t_rsp  o_rsp
);
    import imhq_pkg::*;

    localparam int unsigned AW  = $clog2(NODE_COUNT);
    localparam int unsigned SW  = $clog2(NODE_COUNT + 1);
    localparam int unsigned EW  = ID_W + KEY_W;

    typedef enum logic [16:0] {
        S_CLEAR = 17'b00000000000000001,
        S_IDLE  = 17'b00000000000000010,
        S_ALOOK = 17'b00000000000000100, // presence + slot read issued
        S_ADEC  = 17'b00000000000001000,
        S_UPRD  = 17'b00000000000010000, // read parent
        S_UPWT  = 17'b00000000000100000,
        S_UPCMP = 17'b00000000001000000,
        S_UPW2  = 17'b00000000010000000, // write child slot + slot table
        S_PRD0  = 17'b00000000100000000, // read root
        S_PRDL  = 17'b00000001000000000, // read last
        S_PWT   = 17'b00000010000000000,
        S_DNRL  = 17'b00000100000000000, // read left
        S_DNRR  = 17'b00001000000000000, // read right
        S_DNWT  = 17'b00010000000000000,
        S_DNCMP = 17'b00100000000000000,
        S_DNW2  = 17'b01000000000000000,
        S_OUT   = 17'b10000000000000000
    } t_state;

    t_state r_state, n_state;

    // heap memory port
    logic          heap_we;
    logic [AW-1:0] heap_addr;
    t_entry        heap_wd, heap_rd;
    // slot table port
    logic          slot_we;
    logic [AW-1:0] slot_addr, slot_wd, slot_rd;
    // presence port
    logic          pres_we;
    logic [AW-1:0] pres_addr;
    logic          pres_wd, pres_rd;

    imhq_ram #(.WIDTH(EW), .DEPTH(NODE_COUNT)) u_heap (
        .i_clk(i_clk), .i_we(heap_we), .i_addr(heap_addr),
        .i_wdata(heap_wd), .o_rdata(heap_rd));
    imhq_ram #(.WIDTH(AW), .DEPTH(NODE_COUNT)) u_slot (
        .i_clk(i_clk), .i_we(slot_we), .i_addr(slot_addr),
        .i_wdata(slot_wd), .o_rdata(slot_rd));
    imhq_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_pres (
        .i_clk(i_clk), .i_we(pres_we), .i_addr(pres_addr),
        .i_wdata(pres_wd), .o_rdata(pres_rd));

    logic [SW-1:0] r_size, n_size;
    logic [AW-1:0] r_clr, n_clr;
    t_req          r_req, n_req;
    t_entry        r_cur, n_cur;       // entry being sifted, held in registers
    logic [AW:0]   r_pos, n_pos;       // its current slot (one spare bit)
    t_entry        r_oth, n_oth;       // parent or left child
    t_entry        r_rgt, n_rgt;       // right child
    logic          r_hasr, n_hasr;
    logic [1:0]    r_status, n_status;
    t_entry        r_pop, n_pop;
    logic          r_ovalid, n_ovalid;

    logic [AW-1:0] node_idx;
    logic [AW:0]   parent, left, right, child;
    logic          take_left;

    // node id reduced modulo the table size
    always_comb begin
        node_idx = AW'(32'(r_req.node_id) % NODE_COUNT);
    end

    assign parent    = (r_pos - 1'b1) >> 1;
    assign left      = {r_pos[AW-1:0], 1'b1};
    assign right     = left + 1'b1;
    assign take_left = !r_hasr || (r_oth.key < r_rgt.key);
    assign child     = take_left ? left : right;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_size   = r_size;
        n_clr    = r_clr;
        n_req    = r_req;
        n_cur    = r_cur;
        n_pos    = r_pos;
        n_oth    = r_oth;
        n_rgt    = r_rgt;
        n_hasr   = r_hasr;
        n_status = r_status;
        n_pop    = r_pop;
        n_ovalid = r_ovalid;
        heap_we  = 1'b0;
        heap_addr = r_pos[AW-1:0];
        heap_wd  = r_cur;
        slot_we  = 1'b0;
        slot_addr = r_cur.id[AW-1:0];
        slot_wd  = r_pos[AW-1:0];
        pres_we  = 1'b0;
        pres_addr = node_idx;
        pres_wd  = 1'b0;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                pres_we   = 1'b1;
                pres_addr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(NODE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_req = i_req;
                    n_pop = '0;
                    if (i_req.req_type == REQ_ADD) begin
                        n_state = S_ALOOK;
                    end else if (r_size == '0) begin
                        n_status = ST_EMPTY;
                        n_state  = S_OUT;
                    end else begin
                        n_status = ST_POPPED;
                        n_state  = S_PRD0;
                    end
                end
            end
            S_ALOOK: begin
                slot_addr = node_idx;
                n_state   = S_ADEC;
            end
            S_ADEC: begin
                n_cur.id  = ID_W'(node_idx);
                n_cur.key = r_req.key;
                if (pres_rd) begin
                    n_status = ST_UPDATED;
                    n_pos    = {1'b0, slot_rd};
                    if ((AW+1)'(slot_rd) < r_size) begin
                        n_state = S_UPRD;
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_status  = ST_INSERTED;
                    pres_we   = 1'b1;
                    pres_wd   = 1'b1;
                    n_pos     = (AW+1)'(r_size);
                    n_size    = r_size + 1'b1;
                    n_state   = S_UPRD;
                end
            end
            S_UPRD: begin
                if (r_pos == '0) begin
                    n_state = S_UPW2;
                end else begin
                    heap_addr = parent[AW-1:0];
                    n_state   = S_UPWT;
                end
            end
            S_UPWT: begin
                n_oth   = heap_rd;
                n_state = S_UPCMP;
            end
            S_UPCMP: begin
                if (r_oth.key > r_cur.key) begin
                    // move parent down into the current slot
                    heap_we   = 1'b1;
                    heap_wd   = r_oth;
                    slot_we   = 1'b1;
                    slot_addr = r_oth.id[AW-1:0];
                    n_pos     = parent;
                    n_state   = S_UPRD;
                end else begin
                    n_state = S_UPW2;
                end
            end
            S_UPW2, S_DNW2: begin
                heap_we = 1'b1;
                slot_we = 1'b1;
                n_state = S_OUT;
            end
            S_PRD0: begin
                heap_addr = '0;
                n_state   = S_PRDL;
            end
            S_PRDL: begin
                n_pop     = heap_rd;
                heap_addr = AW'(r_size - 1'b1);
                pres_addr = heap_rd.id[AW-1:0];
                pres_we   = 1'b1;
                n_size    = r_size - 1'b1;
                n_state   = S_PWT;
            end
            S_PWT: begin
                n_cur = heap_rd;
                n_pos = '0;
                if (r_size == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_DNRL;
                end
            end
            S_DNRL: begin
                if (left >= (AW+1)'(r_size)) begin
                    n_state = S_DNW2;
                end else begin
                    heap_addr = left[AW-1:0];
                    n_hasr    = right < (AW+1)'(r_size);
                    n_state   = S_DNRR;
                end
            end
            S_DNRR: begin
                n_oth     = heap_rd;
                heap_addr = right[AW-1:0];
                n_state   = S_DNWT;
            end
            S_DNWT: begin
                if (r_hasr) begin
                    n_rgt = heap_rd;
                end
                n_state = S_DNCMP;
            end
            S_DNCMP: begin
                if (r_cur.key > (take_left ? r_oth.key : r_rgt.key)) begin
                    heap_we   = 1'b1;
                    heap_wd   = take_left ? r_oth : r_rgt;
                    slot_we   = 1'b1;
                    slot_addr = heap_wd.id[AW-1:0];
                    n_pos     = child;
                    n_state   = S_DNRL;
                end else begin
                    n_state = S_DNW2;
                end
            end
            S_OUT: begin
                if (!r_ovalid) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_size   <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_size   <= n_size;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
        r_req    <= n_req;
        r_cur    <= n_cur;
        r_pos    <= n_pos;
        r_oth    <= n_oth;
        r_rgt    <= n_rgt;
        r_hasr   <= n_hasr;
        r_status <= n_status;
        r_pop    <= n_pop;
    end

    // result item; pop fields are zero unless popped
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && !r_ovalid) begin
            o_rsp.status      <= r_status;
            o_rsp.out_node    <= r_pop.id;
            o_rsp.out_key     <= r_pop.key;
            o_rsp.entry_count <= CNT_W'(r_size);
        end
    end

    // the heap never holds more entries than nodes
    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size <= SW'(NODE_COUNT)) else $error("heap size beyond capacity");
    // no item is taken while a result is still being built
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid) |=> !o_ready) else $error("second item accepted");
    // the size moves by at most one per cycle
    a_size_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_size == $past(r_size) || r_size == $past(r_size) + 1'b1
                            || r_size == $past(r_size) - 1'b1))
        else $error("size jumped");
endmodule

@@ test/testbench.sv @@
// testbench for the indexed min-heap queue: directed table, random traffic, heap predictor
`timescale 1ns / 1ps

module testbench;
    import imhq_pkg::*;

    localparam int unsigned NODES      = NODE_COUNT;
    localparam int unsigned RAND_ITEMS = 800;
    localparam int unsigned FILL_ITEMS = 400;
    localparam int unsigned LIMIT      = 2000000;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_req  i_req;
    logic  o_valid;
    logic  i_ready;
    t_rsp  o_rsp;

    indexed_min_heap_queue_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // predictor state: a software copy of the heap and its index table
    logic [ID_W-1:0]  pq_ids   [NODES];
    logic [KEY_W-1:0] pq_keys  [NODES];
    int unsigned      pq_slot  [NODES];
    bit               pq_here  [NODES];
    int unsigned      pq_size;

    t_rsp        rsp_pending[$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // directed table: request plus an optional typed-in answer
    typedef struct {
        t_req req;
        bit   fixed;
        t_rsp rsp;
    } t_row;
    t_row plan[$];

    function automatic void pq_swap(int unsigned a, int unsigned b);
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] k;
        id = pq_ids[a];
        k  = pq_keys[a];
        pq_ids[a]  = pq_ids[b];
        pq_keys[a] = pq_keys[b];
        pq_ids[b]  = id;
        pq_keys[b] = k;
        pq_slot[pq_ids[a]] = a;
        pq_slot[pq_ids[b]] = b;
    endfunction

    function automatic void pq_rise(int unsigned i);
        int unsigned p;
        while (i > 0 && i < pq_size) begin
            p = (i - 1) / 2;
            if (pq_keys[p] > pq_keys[i]) begin
                pq_swap(p, i);
                i = p;
            end else begin
                break;
            end
        end
    endfunction

    // sift down from the root, right child wins on equal keys
    function automatic void pq_sink();
        int unsigned i;
        int unsigned l;
        int unsigned c;
        i = 0;
        forever begin
            l = 2 * i + 1;
            if (l >= pq_size) break;
            c = l;
            if (l + 1 < pq_size) c = (pq_keys[l] < pq_keys[l + 1]) ? l : l + 1;
            if (pq_keys[i] > pq_keys[c]) begin
                pq_swap(i, c);
                i = c;
            end else begin
                break;
            end
        end
    endfunction

    function automatic t_rsp pq_apply(t_req r);
        t_rsp        o;
        int unsigned id;
        int unsigned s;
        o = '0;
        id = r.node_id % NODES;
        if (r.req_type == REQ_ADD) begin
            if (pq_here[id]) begin
                // key rewritten in place, only ever sifted up
                s = pq_slot[id];
                if (s < pq_size) begin
                    pq_keys[s] = r.key;
                    pq_rise(s);
                end
                o.status = ST_UPDATED;
            end else begin
                s = pq_size;
                pq_ids[s]   = ID_W'(id);
                pq_keys[s]  = r.key;
                pq_slot[id] = s;
                pq_here[id] = 1'b1;
                pq_size     = s + 1;
                pq_rise(s);
                o.status = ST_INSERTED;
            end
        end else if (pq_size == 0) begin
            o.status = ST_EMPTY;
        end else begin
            o.out_node = pq_ids[0];
            o.out_key  = pq_keys[0];
            pq_here[pq_ids[0]] = 1'b0;
            pq_size = pq_size - 1;
            if (pq_size > 0) begin
                // last entry to the root, slot always rewritten
                pq_ids[0]  = pq_ids[pq_size];
                pq_keys[0] = pq_keys[pq_size];
                pq_slot[pq_ids[0]] = 0;
                pq_sink();
            end
            o.status = ST_POPPED;
        end
        o.entry_count = CNT_W'(pq_size);
        return o;
    endfunction

    function automatic t_req mk_req(logic t, logic [ID_W-1:0] id, logic [KEY_W-1:0] k);
        t_req r;
        r.req_type = t;
        r.node_id  = id;
        r.key      = k;
        return r;
    endfunction

    function automatic t_rsp mk_rsp(logic [1:0] st, logic [ID_W-1:0] n,
                                    logic [KEY_W-1:0] k, logic [CNT_W-1:0] c);
        t_rsp o;
        o.status      = st;
        o.out_node    = n;
        o.out_key     = k;
        o.entry_count = c;
        return o;
    endfunction

    function automatic void add_row(t_req r, bit fx, t_rsp o);
        t_row w;
        w.req   = r;
        w.fixed = fx;
        w.rsp   = o;
        plan.insert(plan.size(), w);
    endfunction

    // random request, pops at the given percentage, with a bias toward a small live id range
    function automatic t_req rand_req(int unsigned pop_pct);
        t_req r;
        r.req_type = ($urandom_range(99) < pop_pct) ? REQ_POP : REQ_ADD;
        case ($urandom_range(3))
            0:       r.node_id = ID_W'($urandom_range(NODES - 1));
            default: r.node_id = ID_W'($urandom_range(63));
        endcase
        case ($urandom_range(4))
            0:       r.key = $urandom();
            1:       r.key = $urandom_range(15);
            2:       r.key = 32'hFFFF_FFF0 | $urandom_range(15);
            default: r.key = $urandom_range(4095) << 16;
        endcase
        return r;
    endfunction

    // one item through the input handshake, expectation queued on acceptance;
    // valid stays up after acceptance unless the next item idles first
    task automatic send_item(t_req r, bit fx, t_rsp want);
        t_rsp model;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (!o_ready);
        model = pq_apply(r);
        rsp_pending.insert(rsp_pending.size(), fx ? want : model);
    endtask

    // receiver: random stalls, compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (rsp_pending.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", o_rsp);
                end else begin
                    want = rsp_pending.pop_front();
                    if (o_rsp.status !== want.status || o_rsp.out_node !== want.out_node ||
                        o_rsp.out_key !== want.out_key ||
                        o_rsp.entry_count !== want.entry_count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: st %0d/%0d node %0d/%0d key %h/%h cnt %0d/%0d",
                                     want.status, o_rsp.status, want.out_node, o_rsp.out_node,
                                     want.out_key, o_rsp.out_key, want.entry_count,
                                     o_rsp.entry_count);
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog, counts cycles from time zero
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        int unsigned phase;
        int unsigned popp;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pq_size        = 0;
        for (int i = 0; i < NODES; i++) pq_here[i] = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_req   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pops, extremes, ties, updates up and down, drain
        add_row(mk_req(REQ_POP, 10'd5, 32'hFFFF_FFFF), 1'b1, mk_rsp(ST_EMPTY, '0, '0, '0));
        add_row(mk_req(REQ_ADD, 10'd1023, 32'hFFFF_FFFF), 1'b1,
                mk_rsp(ST_INSERTED, '0, '0, 11'd1));
        add_row(mk_req(REQ_ADD, 10'd0, 32'h0), 1'b1, mk_rsp(ST_INSERTED, '0, '0, 11'd2));
        add_row(mk_req(REQ_ADD, 10'd0, 32'h0000_0001), 1'b1,
                mk_rsp(ST_UPDATED, '0, '0, 11'd2));
        add_row(mk_req(REQ_ADD, 10'h155, 32'h0001_0000), 1'b0, '0);
        add_row(mk_req(REQ_ADD, 10'h2AA, 32'h0001_0000), 1'b0, '0);
        add_row(mk_req(REQ_ADD, 10'd7, 32'h0001_0000), 1'b0, '0);
        add_row(mk_req(REQ_ADD, 10'd8, 32'h8000_0000), 1'b0, '0);
        // update to a larger key, no sift down
        add_row(mk_req(REQ_ADD, 10'd0, 32'hFFFF_FFFE), 1'b0, '0);
        add_row(mk_req(REQ_ADD, 10'd8, 32'h0), 1'b0, '0);
        add_row(mk_req(REQ_POP, 10'h3FF, 32'h0), 1'b1,
                mk_rsp(ST_POPPED, 10'd8, 32'h0, 11'd5));
        for (int i = 0; i < 7; i++) add_row(mk_req(REQ_POP, 10'd0, 32'h0), 1'b0, '0);
        add_row(mk_req(REQ_POP, 10'd0, 32'h0), 1'b1, mk_rsp(ST_EMPTY, '0, '0, '0));
        foreach (plan[i]) send_item(plan[i].req, plan[i].fixed, plan[i].rsp);

        // random phases with differing idling; pop share swings so the heap grows and drains
        n = 0;
        phase = 0;
        while (n < RAND_ITEMS) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            popp = (phase % 3 == 0) ? 15 : (phase % 3 == 1) ? 45 : 70;
            for (int i = 0; i < 200; i++) send_item(rand_req(popp), 1'b0, '0);
            n += 200;
            phase++;
        end

        // grow a deep heap once so long sifts are exercised, then drain
        send_idle_pct = 0;
        recv_stall_pct = 10;
        for (int i = 0; i < FILL_ITEMS; i++)
            send_item(mk_req(REQ_ADD, ID_W'(i), $urandom()), 1'b0, '0);
        for (int i = 0; i < FILL_ITEMS + 1; i++)
            send_item(mk_req(REQ_POP, '0, '0), 1'b0, '0);
        i_valid <= 1'b0;

        while (rsp_pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
